>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the defragmentation candidate selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DCS_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("defrag selector: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DCS_ASSERT_NXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("defrag selector: next-cycle check failed");

`endif

>>> rtl/dcs_pkg.sv
// Shared constants, types and helper functions of the defragmentation candidate selector.
package dcs_pkg;

	localparam int MAX_BLOCKS      = 64;
	localparam int LINES_PER_BLOCK = 248;
	localparam int HOLE_BINS       = LINES_PER_BLOCK / 2 + 2;

	localparam int MARK_W    = 8;
	localparam int HOLE_W    = 7;
	localparam int TGT_W     = 12;
	localparam int ENT_W     = MARK_W + HOLE_W;
	localparam int OUT_IDX_W = 6;
	localparam int OUT_CNT_W = 7;
	localparam int OUT_REQ_W = 14;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int BIN_W = $clog2(HOLE_BINS + 1);
	// The budget is below 2^TGT_W * 2^ceil(log2(LINES_PER_BLOCK)).
	localparam int BUD_W = TGT_W + $clog2(LINES_PER_BLOCK);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	typedef logic [BIN_W-1:0] bin_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // append the input beat to the table
		logic start;    // latch the budget and begin the first scan
		logic scan;     // advance the running table scan
		logic take;     // choose the best block of the scan and rescan the bin
		logic next_bin; // move to the next lower occupied bin and rescan
		logic emit;     // load one result into the output register
		logic finish;   // clear the table fill count
	} dcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;     // no entries loaded
		logic scan_done; // all reads of the current scan have been evaluated
		logic fit;       // a candidate was found and it fits in the budget
		logic next_zero; // no eligible block lies in a lower bin
		logic emit_last; // the next emitted result is the final one
		logic out_free;  // the output register can take a result this cycle
	} dcs_sts_t;

	function automatic bin_t bin_of(input logic [HOLE_W-1:0] holes);
		if (int'(holes) < HOLE_BINS) begin
			return bin_t'(holes);
		end else begin
			return bin_t'(HOLE_BINS - 1);
		end
	endfunction

	function automatic logic eligible(input logic [MARK_W-1:0] marked,
		input logic [HOLE_W-1:0] holes);
		return (marked != '0) && (int'(marked) < LINES_PER_BLOCK) && (holes != '0);
	endfunction

endpackage

>>> rtl/dcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/dcs_ctrl.sv
// Controller state machine that sequences loads, bin scans and result emission.
module dcs_ctrl
	import dcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      command,
	output logic      in_stall,
	input  dcs_sts_t  sts,
	output dcs_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_LOAD) begin
					cmd.load = 1'b1;
				end
				if (accept && command == CMD_SELECT && !sts.empty) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					priority if (sts.fit) begin
						cmd.take = 1'b1;
					end else if (sts.next_zero) begin
						state_d = ST_EMIT;
					end else begin
						cmd.next_bin = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/dcs_datapath.sv
// Datapath: block table, chosen flags, bin scan evaluation, totals and output register.
module dcs_datapath
	import dcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcs_cmd_t             cmd,
	output dcs_sts_t             sts,
	input  logic [MARK_W-1:0]    marked_lines,
	input  logic [HOLE_W-1:0]    hole_count,
	input  logic [TGT_W-1:0]     target_blocks,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [OUT_IDX_W-1:0] block_index,
	output logic                 selected,
	output logic                 last,
	output logic [OUT_CNT_W-1:0] selected_count,
	output logic [OUT_REQ_W-1:0] required_lines,
	output logic                 evac_active
);

	logic [CNT_W-1:0]      count_q;
	logic [BUD_W-1:0]      budget_q;
	logic [BUD_W-1:0]      required_q;
	logic [CNT_W-1:0]      nsel_q;
	bin_t                  cur_bin_q;
	bin_t                  next_bin_q;
	logic [IDX_W-1:0]      best_q;
	logic [MARK_W-1:0]     best_m_q;
	logic                  found_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  issue_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      emit_q;
	logic                  out_valid_q;

	logic                  ram_we;
	logic [ENT_W-1:0]      ram_rdata;
	logic                  chosen_we;
	logic [IDX_W-1:0]      chosen_waddr;
	logic [IDX_W-1:0]      chosen_raddr;
	logic [IDX_W-1:0]      emit_nxt;
	logic                  chosen_rdata;
	logic [MARK_W-1:0]     rd_marked;
	logic [HOLE_W-1:0]     rd_holes;
	logic                  rd_elig;
	bin_t                  rd_bin;
	logic                  restart;
	logic                  last_addr;
	logic                  table_full;
	logic [BUD_W:0]        trial_sum;

	assign table_full = (count_q == CNT_W'(MAX_BLOCKS));
	assign ram_we     = cmd.load && !table_full;

	dcs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({marked_lines, hole_count}),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Chosen flags. A load clears the flag of its new entry, so only entries below the
	// fill count are ever read and no clearing pass is needed. During a scan the flag is
	// read beside the table entry; otherwise the read runs one entry ahead of the emitter.
	assign chosen_we    = ram_we || cmd.take;
	assign chosen_waddr = cmd.take ? best_q : count_q[IDX_W-1:0];
	assign emit_nxt     = cmd.emit ? (emit_q + IDX_W'(1)) : emit_q;
	assign chosen_raddr = issue_q ? addr_q : emit_nxt;

	dcs_ram #(
		.WIDTH (1),
		.DEPTH (MAX_BLOCKS)
	) u_chosen (
		.clk   (clk),
		.we    (chosen_we),
		.waddr (chosen_waddr),
		.wdata (cmd.take),
		.raddr (chosen_raddr),
		.rdata (chosen_rdata)
	);

	assign rd_marked = ram_rdata[ENT_W-1:HOLE_W];
	assign rd_holes  = ram_rdata[HOLE_W-1:0];
	assign rd_elig   = eligible(rd_marked, rd_holes);
	assign rd_bin    = bin_of(rd_holes);

	assign restart   = cmd.start || cmd.take || cmd.next_bin;
	assign last_addr = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
	assign trial_sum = {1'b0, required_q} + (BUD_W + 1)'(best_m_q);

	assign sts.empty     = (count_q == '0);
	assign sts.scan_done = !issue_q && !vld_s1;
	assign sts.fit       = found_q && (trial_sum <= {1'b0, budget_q});
	assign sts.next_zero = (next_bin_q == '0);
	assign sts.emit_last = ((CNT_W'(emit_q) + CNT_W'(1)) == count_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Table fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				count_q <= '0;
			end
		end
	end

	// Read sequencing of one scan: one table read a cycle, data evaluated in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else if (restart) begin
			issue_q <= 1'b1;
			vld_s1  <= 1'b0;
		end else if (cmd.scan) begin
			vld_s1 <= issue_q;
			if (issue_q && last_addr) begin
				issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			addr_q     <= '0;
			found_q    <= 1'b0;
			next_bin_q <= '0;
		end else if (cmd.scan) begin
			idx_s1 <= addr_q;
			if (issue_q) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (vld_s1) begin
				if (rd_elig && !chosen_rdata && rd_bin == cur_bin_q &&
					(!found_q || rd_marked < best_m_q)) begin
					found_q  <= 1'b1;
					best_q   <= idx_s1;
					best_m_q <= rd_marked;
				end
				if (rd_elig && rd_bin < cur_bin_q && rd_bin > next_bin_q) begin
					next_bin_q <= rd_bin;
				end
			end
		end
	end

	// Budget, running totals, current bin and emit position.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			budget_q   <= BUD_W'(int'(target_blocks) * LINES_PER_BLOCK);
			required_q <= '0;
			nsel_q     <= '0;
			cur_bin_q  <= bin_t'(HOLE_BINS);
			emit_q     <= '0;
		end
		if (cmd.take) begin
			required_q <= trial_sum[BUD_W-1:0];
			nsel_q     <= nsel_q + CNT_W'(1);
		end
		if (cmd.next_bin) begin
			cur_bin_q <= next_bin_q;
		end
		if (cmd.emit) begin
			emit_q <= emit_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			block_index <= OUT_IDX_W'(emit_q);
			selected    <= chosen_rdata;
			last        <= sts.emit_last;
			if (sts.emit_last) begin
				selected_count <= OUT_CNT_W'(nsel_q);
				required_lines <= OUT_REQ_W'(required_q);
				evac_active    <= (budget_q != '0) && (nsel_q != '0);
			end else begin
				selected_count <= '0;
				required_lines <= '0;
				evac_active    <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/defrag_candidate_selector.sv
// Top level of the defragmentation candidate selector: controller, datapath and checks.
//
//   Channel  Direction  Handshake           Beat payload
//   in       input      in_valid/in_stall   command, marked_lines, hole_count, target_blocks
//   out      output     out_valid/out_stall block_index, selected, last, selected_count,
//                                           required_lines, evac_active
//
// Load beats are accepted without stalling, so loads can stream in back to back.
// A select beat with n loaded blocks runs a number of table scans, each reading all n entries
// through the single read port of the block table; there is one scan per chosen block,
// one per occupied bin visited, and one to find the highest occupied bin.
// It then emits n result beats, one per cycle when out_stall is low, and clears the table.
// While a select runs, in_stall is high; the output register lets a new load be taken while
// the final result still waits. Reset clears the fill count; each load clears the chosen
// flag of its own entry, so the flag store needs no clearing pass.
`include "assert_macros.svh"

module defrag_candidate_selector
	import dcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [MARK_W-1:0]    marked_lines,
	input  logic [HOLE_W-1:0]    hole_count,
	input  logic [TGT_W-1:0]     target_blocks,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_IDX_W-1:0] block_index,
	output logic                 selected,
	output logic                 last,
	output logic [OUT_CNT_W-1:0] selected_count,
	output logic [OUT_REQ_W-1:0] required_lines,
	output logic                 evac_active
);

	dcs_cmd_t cmd;
	dcs_sts_t sts;
	logic     start_scan;
	logic     last_beat;

	// The controller decides what happens each cycle from the datapath status.
	dcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table, runs the scans and owns the output register.
	dcs_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.marked_lines   (marked_lines),
		.hole_count     (hole_count),
		.target_blocks  (target_blocks),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.block_index    (block_index),
		.selected       (selected),
		.last           (last),
		.selected_count (selected_count),
		.required_lines (required_lines),
		.evac_active    (evac_active)
	);

	// A select beat taken while the table holds entries starts the scans.
	assign start_scan = in_valid && !in_stall && command == CMD_SELECT && !sts.empty;
	// The final result beat of a run is on the output.
	assign last_beat  = out_valid && last;

	// A select on a non-empty table must hold off the input side on the next cycle.
	`DCS_ASSERT_NXT(a_select_busy, start_scan, in_stall)

	// Every chosen block has at least one marked line, so a zero count means zero lines.
	`DCS_ASSERT_IMP(a_zero_count_zero_lines, last_beat && selected_count == '0, required_lines == '0)

	// Any chosen block implies a nonzero budget, so evacuation is then active.
	`DCS_ASSERT_IMP(a_count_means_active, last_beat && selected_count != '0, evac_active)

endmodule
